// ===== src/bcg_pkg.sv =====
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants of the breakpoint curve generator.
// ----------------------------------------------------------------------------
package bcg_pkg;

	localparam int MaxPoints = 16;
	localparam int MaxLength = 4096;

	localparam int AddrW  = $clog2(MaxPoints);
	localparam int CountW = $clog2(MaxPoints + 1);
	localparam int FreqW  = 16;
	localparam int MagW   = 24;
	localparam int LenW   = $clog2(MaxLength + 1);
	localparam int IdxW   = 12;
	localparam int CurW   = $clog2(MaxLength);
	localparam int MapW   = FreqW + LenW;
	localparam int ProdW  = MagW + 1 + CurW + 1;
	localparam int DivW   = (ProdW > MapW) ? ProdW : MapW;
	localparam int DivCntW = $clog2(DivW + 1);
	localparam int EntryW = FreqW + MagW;

	localparam logic [1:0] StatusOk   = 2'd0;
	localparam logic [1:0] StatusHigh = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;

	localparam logic RegUpperFreq = 1'b0;
	localparam logic RegOutLength = 1'b1;

	localparam logic ModeInsert = 1'b0;

	typedef struct packed {
		logic signed [MagW-1:0] mag;
		logic [FreqW-1:0]       freq;
	} bp_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_SMP_RD,
		ST_SMP_MAP,
		ST_SMP_DIVW,
		ST_SMP_SEG,
		ST_SMP_ADV,
		ST_SMP_TEST,
		ST_SMP_MUL,
		ST_SMP_QST,
		ST_SMP_QW,
		ST_OUT
	} state_t;

endpackage

// ===== src/breakpoint_curve_generator.sv =====
// ----------------------------------------------------------------------------
// breakpoint_curve_generator
// Sorted breakpoint table with a piecewise linear curve sampler.
// ----------------------------------------------------------------------------
// Breakpoints live in a 16 x 40 bit RAM sorted by frequency. An insert walks
// the table from the top, one read and one write-back per entry it moves, and
// then writes the new point; a rejected insert writes nothing. A sample walks
// the segments from the first point. Each breakpoint read takes the RAM read,
// a pass of the shared bit-serial divider for the index mapping (start, the 38
// quotient bits, done) and the segment step. Each segment is tested in turn,
// and the interpolation multiplies and then runs the divider once more. A
// sample below the first point or on an empty table skips the interpolation,
// and with a zero upper frequency no divide runs. A full result register holds
// the generator in its output state. One item is worked on at a time; the
// result register lets the next item in while a result waits. No clearing
// pass follows reset.
module breakpoint_curve_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // point_freq[15:0], point_magnitude[39:16]
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // status[1:0], sample_index[13:2],
	                                    // sample_value[37:14], zero[39:38]
	output logic        m_axis_tuser,   // sample_written
	output logic        m_axis_tlast,   // last_sample
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	bcg_pkg::state_t state_q, state_d;

	logic [bcg_pkg::FreqW-1:0]       upper_q;
	logic [bcg_pkg::LenW-1:0]        olen_q;
	logic [bcg_pkg::CountW-1:0]      count_q;
	logic [bcg_pkg::CurW-1:0]        cursor_q;
	logic                            mode_q;
	logic [bcg_pkg::FreqW-1:0]       f_q;
	logic signed [bcg_pkg::MagW-1:0] m_q;
	logic [bcg_pkg::AddrW-1:0]       i_q;
	logic                            first_q;
	logic [bcg_pkg::LenW-1:0]        len_q;
	logic [bcg_pkg::CurW-1:0]        j_q;
	logic [bcg_pkg::MapW-1:0]        lo_q, hi_q, mapped_q;
	logic signed [bcg_pkg::MagW-1:0] m0_q, m1_q;
	logic signed [bcg_pkg::ProdW-1:0] prod_q;
	logic [1:0]                      res_status_q;
	logic [bcg_pkg::MagW-1:0]        res_value_q;
	logic                            res_written_q;

	logic                            ov_q;
	logic [1:0]                      o_status_q;
	logic [bcg_pkg::IdxW-1:0]        o_index_q;
	logic [bcg_pkg::MagW-1:0]        o_value_q;
	logic                            o_written_q;
	logic                            o_last_q;

	logic                            ram_we;
	logic [bcg_pkg::AddrW-1:0]       ram_waddr, ram_raddr;
	bcg_pkg::bp_entry_t              ram_wdata, ram_rdata;
	logic                            div_start, div_busy, div_done;
	logic [bcg_pkg::DivW-1:0]        div_dividend, div_quotient;
	logic [bcg_pkg::MapW-1:0]        div_divisor;

	logic [bcg_pkg::LenW-1:0]        len_eff;
	logic                            in_xfer, out_slot_free, is_last;
	logic [bcg_pkg::AddrW-1:0]       i_inc;
	logic                            has_next;
	logic signed [bcg_pkg::MagW:0]   mag_diff;
	logic signed [bcg_pkg::CurW+1:0] idx_off;
	logic signed [bcg_pkg::ProdW-1:0] prod_d;
	logic [bcg_pkg::DivW-1:0]        prod_abs, q_signed;

	bcg_ram #(
		.Width (bcg_pkg::EntryW),
		.Depth (bcg_pkg::MaxPoints)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		if (olen_q == '0) begin
			len_eff = bcg_pkg::LenW'(1);
		end else if (olen_q > bcg_pkg::LenW'(bcg_pkg::MaxLength)) begin
			len_eff = bcg_pkg::LenW'(bcg_pkg::MaxLength);
		end else begin
			len_eff = olen_q;
		end
	end

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_slot_free = !ov_q || m_axis_tready;
	assign is_last       = mode_q && ({1'b0, j_q} == len_q - 1'b1);
	assign i_inc         = i_q + 1'b1;
	assign has_next      = ({1'b0, i_q} + 1'b1) < count_q;
	assign mag_diff      = {m1_q[bcg_pkg::MagW-1], m1_q} - {m0_q[bcg_pkg::MagW-1], m0_q};
	assign idx_off       = {2'b00, j_q - lo_q[bcg_pkg::CurW-1:0]};
	assign prod_d        = mag_diff * idx_off;
	assign prod_abs      = prod_q[bcg_pkg::ProdW-1] ? bcg_pkg::DivW'(-prod_q)
	                                                : bcg_pkg::DivW'(prod_q);
	assign q_signed      = prod_q[bcg_pkg::ProdW-1] ? -div_quotient : div_quotient;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bcg_pkg::ST_IDLE:     if (in_xfer) state_d = bcg_pkg::ST_DECODE;
			bcg_pkg::ST_DECODE: begin
				if (mode_q == bcg_pkg::ModeInsert) begin
					if (f_q > upper_q || count_q >= bcg_pkg::CountW'(bcg_pkg::MaxPoints)) begin
						state_d = bcg_pkg::ST_OUT;
					end else if (count_q == '0) begin
						state_d = bcg_pkg::ST_INS_PUT;
					end else begin
						state_d = bcg_pkg::ST_INS_RD;
					end
				end else if (count_q == '0) begin
					state_d = bcg_pkg::ST_OUT;
				end else begin
					state_d = bcg_pkg::ST_SMP_RD;
				end
			end
			bcg_pkg::ST_INS_RD:   state_d = bcg_pkg::ST_INS_CMP;
			bcg_pkg::ST_INS_CMP: begin
				if (f_q <= ram_rdata.freq && i_q != '0) begin
					state_d = bcg_pkg::ST_INS_RD;
				end else begin
					state_d = bcg_pkg::ST_INS_PUT;
				end
			end
			bcg_pkg::ST_INS_PUT:  state_d = bcg_pkg::ST_OUT;
			bcg_pkg::ST_SMP_RD:   state_d = bcg_pkg::ST_SMP_MAP;
			bcg_pkg::ST_SMP_MAP:  state_d = (upper_q == '0) ? bcg_pkg::ST_SMP_SEG
			                                                : bcg_pkg::ST_SMP_DIVW;
			bcg_pkg::ST_SMP_DIVW: if (div_done) state_d = bcg_pkg::ST_SMP_SEG;
			bcg_pkg::ST_SMP_SEG: begin
				if (!first_q) begin
					state_d = bcg_pkg::ST_SMP_TEST;
				end else if (mapped_q > {{(bcg_pkg::MapW-bcg_pkg::CurW){1'b0}}, j_q}) begin
					state_d = bcg_pkg::ST_OUT;
				end else begin
					state_d = bcg_pkg::ST_SMP_ADV;
				end
			end
			bcg_pkg::ST_SMP_ADV:  state_d = has_next ? bcg_pkg::ST_SMP_RD : bcg_pkg::ST_SMP_TEST;
			bcg_pkg::ST_SMP_TEST: begin
				if ({{(bcg_pkg::MapW-bcg_pkg::CurW){1'b0}}, j_q} < hi_q) begin
					state_d = bcg_pkg::ST_SMP_MUL;
				end else begin
					state_d = bcg_pkg::ST_SMP_ADV;
				end
			end
			bcg_pkg::ST_SMP_MUL:  state_d = bcg_pkg::ST_SMP_QST;
			bcg_pkg::ST_SMP_QST:  state_d = bcg_pkg::ST_SMP_QW;
			bcg_pkg::ST_SMP_QW:   if (div_done) state_d = bcg_pkg::ST_OUT;
			bcg_pkg::ST_OUT:      if (out_slot_free) state_d = bcg_pkg::ST_IDLE;
			default:              state_d = bcg_pkg::ST_IDLE;
		endcase
	end

	// memory and divider control
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = i_q;
		ram_wdata    = '{mag: m_q, freq: f_q};
		ram_raddr    = i_q;
		div_start    = 1'b0;
		div_dividend = bcg_pkg::DivW'(ram_rdata.freq) * bcg_pkg::DivW'(len_q);
		div_divisor  = {{(bcg_pkg::MapW-bcg_pkg::FreqW){1'b0}}, upper_q};
		unique case (state_q)
			bcg_pkg::ST_INS_CMP: begin
				if (f_q <= ram_rdata.freq) begin
					// shift the entry up one slot
					ram_we    = 1'b1;
					ram_waddr = i_inc;
					ram_wdata = ram_rdata;
				end
			end
			bcg_pkg::ST_INS_PUT: ram_we = 1'b1;
			bcg_pkg::ST_SMP_MAP: div_start = upper_q != '0;
			bcg_pkg::ST_SMP_QST: begin
				div_start    = 1'b1;
				div_dividend = prod_abs;
				div_divisor  = hi_q - lo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bcg_pkg::ST_IDLE;
			upper_q  <= bcg_pkg::FreqW'(22050);
			olen_q   <= bcg_pkg::LenW'(1024);
			count_q  <= '0;
			cursor_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == bcg_pkg::RegUpperFreq) begin
					upper_q <= cfg_data;
				end else begin
					olen_q <= cfg_data[bcg_pkg::LenW-1:0];
				end
			end
			if (state_q == bcg_pkg::ST_INS_PUT) begin
				count_q <= count_q + 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			if (state_q == bcg_pkg::ST_OUT && out_slot_free) begin
				ov_q <= 1'b1;
				if (mode_q != bcg_pkg::ModeInsert) begin
					cursor_q <= is_last ? '0 : j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bcg_pkg::ST_IDLE: begin
				if (in_xfer) begin
					mode_q <= s_axis_tuser;
					f_q    <= s_axis_tdata[15:0];
					m_q    <= s_axis_tdata[39:16];
				end
			end
			bcg_pkg::ST_DECODE: begin
				res_status_q  <= bcg_pkg::StatusOk;
				res_value_q   <= '0;
				res_written_q <= 1'b0;
				len_q         <= len_eff;
				first_q       <= 1'b1;
				j_q           <= ({1'b0, cursor_q} >= len_eff) ? '0 : cursor_q;
				if (mode_q == bcg_pkg::ModeInsert) begin
					if (f_q > upper_q) begin
						res_status_q <= bcg_pkg::StatusHigh;
					end else if (count_q >= bcg_pkg::CountW'(bcg_pkg::MaxPoints)) begin
						res_status_q <= bcg_pkg::StatusFull;
					end
					i_q <= (count_q == '0) ? '0 : bcg_pkg::AddrW'(count_q - 1'b1);
				end else begin
					i_q <= '0;
				end
			end
			bcg_pkg::ST_INS_CMP: begin
				// stop at the slot above the first lower entry
				if (f_q > ram_rdata.freq) begin
					i_q <= i_inc;
				end else if (i_q != '0) begin
					i_q <= i_q - 1'b1;
				end
			end
			bcg_pkg::ST_SMP_MAP: begin
				m1_q <= ram_rdata.mag;
				if (upper_q == '0) begin
					mapped_q <= {{(bcg_pkg::MapW-bcg_pkg::LenW){1'b0}}, len_q};
				end
			end
			bcg_pkg::ST_SMP_DIVW: begin
				if (div_done) begin
					mapped_q <= div_quotient[bcg_pkg::MapW-1:0];
				end
			end
			bcg_pkg::ST_SMP_SEG: begin
				if (first_q) begin
					lo_q    <= mapped_q;
					m0_q    <= m1_q;
					first_q <= 1'b0;
				end else begin
					hi_q <= mapped_q;
				end
			end
			bcg_pkg::ST_SMP_ADV: begin
				if (has_next) begin
					i_q <= i_inc;
				end else begin
					// implicit end point at the curve length with zero magnitude
					hi_q <= {{(bcg_pkg::MapW-bcg_pkg::LenW){1'b0}}, len_q};
					m1_q <= '0;
				end
			end
			bcg_pkg::ST_SMP_TEST: begin
				if ({{(bcg_pkg::MapW-bcg_pkg::CurW){1'b0}}, j_q} >= hi_q) begin
					lo_q <= hi_q;
					m0_q <= m1_q;
				end
			end
			bcg_pkg::ST_SMP_MUL: prod_q <= prod_d;
			bcg_pkg::ST_SMP_QW: begin
				if (div_done) begin
					res_value_q   <= m0_q + q_signed[bcg_pkg::MagW-1:0];
					res_written_q <= 1'b1;
				end
			end
			bcg_pkg::ST_OUT: begin
				if (out_slot_free) begin
					o_status_q  <= res_status_q;
					o_index_q   <= (mode_q == bcg_pkg::ModeInsert) ? '0 : j_q;
					o_value_q   <= res_value_q;
					o_written_q <= res_written_q;
					o_last_q    <= is_last;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = state_q == bcg_pkg::ST_IDLE;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {2'b00, o_value_q, o_index_q, o_status_q};
	assign m_axis_tuser  = o_written_q;
	assign m_axis_tlast  = o_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bcg_pkg::CountW'(bcg_pkg::MaxPoints))
		else $error("breakpoint count beyond table depth");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_segment_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcg_pkg::ST_SMP_MUL |->
			lo_q <= {{(bcg_pkg::MapW-bcg_pkg::CurW){1'b0}}, j_q} &&
			{{(bcg_pkg::MapW-bcg_pkg::CurW){1'b0}}, j_q} < hi_q)
		else $error("interpolation outside its segment");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcg_pkg::ST_INS_PUT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

endmodule

// ===== src/bcg_ram.sv =====
// ----------------------------------------------------------------------------
// bcg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bcg_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/bcg_div.sv =====
// ----------------------------------------------------------------------------
// bcg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bcg_pkg::DivW-1:0]    dividend,
	input  logic [bcg_pkg::MapW-1:0]    divisor,
	output logic                        busy,
	output logic                        done,
	output logic [bcg_pkg::DivW-1:0]    quotient
);

	logic [bcg_pkg::DivCntW-1:0] cnt_q;
	logic                        done_q;
	logic [bcg_pkg::DivW-1:0]    quo_q;
	logic [bcg_pkg::MapW-1:0]    rem_q;
	logic [bcg_pkg::MapW-1:0]    dsr_q;
	logic [bcg_pkg::MapW:0]      trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[bcg_pkg::DivW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= bcg_pkg::DivCntW'(bcg_pkg::DivW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bcg_pkg::DivCntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the top trial bit drops out
			rem_q <= fits ? bcg_pkg::MapW'(trial - {1'b0, dsr_q}) : trial[bcg_pkg::MapW-1:0];
			quo_q <= {quo_q[bcg_pkg::DivW-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
